FILE: rtl/rdq_pkg.sv
// Shared types and codes for the ring deque.
// No dependencies; used by ring_deque.
`default_nettype none

package rdq_pkg;

    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;
    localparam int IO_W    = 32;

    localparam logic [CAP_W-1:0] RESET_CAPACITY = 5'd16;

    localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
    localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [2:0] CMD_PEEK_HEAD = 3'd4;
    localparam logic [2:0] CMD_PEEK_TAIL = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               has_data;
    } rdq_result_t;

endpackage

`default_nettype wire

FILE: rtl/ring_deque.sv
// Ring deque top level: command decode, pointers, slot memory, output stages.
// Depends on rdq_pkg.
`default_nettype none

// Channel   Ports                                  Direction
// command   s_valid s_ready s_command s_data_in    in
// result    m_valid m_ready m_data_out m_status m_count   out
// config    cfg_wr_en cfg_wr_data                  in
//
// One word accepted per cycle while s_ready is high; results are registered outputs.
// The pointers and count update at the accept edge; the slot read is registered.
// A read stage and an output register part the channels: one more command is
// taken while a result stalls. aresetn clears the queue, capacity returns to 16.
// Capacity writes empty the queue at once.
module ring_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [2:0]                 s_command,
    input  wire  [rdq_pkg::IO_W-1:0]   s_data_in,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [rdq_pkg::IO_W-1:0]   m_data_out,
    output logic [1:0]                 m_status,
    output logic [rdq_pkg::COUNT_W-1:0] m_count,
    input  wire                        cfg_wr_en,
    input  wire  [rdq_pkg::CAP_W-1:0]  cfg_wr_data
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CAPW = $clog2(DEPTH + 1);

    function automatic logic [CAPW-1:0] eff_cap(input logic [rdq_pkg::CAP_W-1:0] v);
        logic [CAPW+rdq_pkg::CAP_W-1:0] e;
        e = {{CAPW{1'b0}}, v};
        if (v == '0) begin
            eff_cap = CAPW'(1);
        end else if (32'(v) > DEPTH) begin
            eff_cap = CAPW'(DEPTH);
        end else begin
            eff_cap = e[CAPW-1:0];
        end
    endfunction

    function automatic logic [IW-1:0] half_cap(input logic [CAPW-1:0] c);
        logic [CAPW-1:0] h;
        h = c >> 1;
        half_cap = IW'(h);
    endfunction

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] i,
                                               input logic [CAPW-1:0] c);
        logic [CAPW:0] s;
        s = (CAPW+1)'(i) + 1'b1;
        if (s >= {1'b0, c}) begin
            ring_inc = '0;
        end else begin
            ring_inc = IW'(s);
        end
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] i,
                                               input logic [CAPW-1:0] c);
        if (i == '0 || CAPW'(i) >= c) begin
            ring_dec = IW'(c - 1'b1);
        end else begin
            ring_dec = i - 1'b1;
        end
    endfunction

    logic [rdq_pkg::CAP_W-1:0] capacity_reg;
    logic [IW-1:0]             head_reg, head_next;
    logic [IW-1:0]             tail_reg, tail_next;
    logic [CAPW-1:0]           occ_reg, occ_next;
    logic [CAPW-1:0]           cap;

    logic [DATA_WIDTH-1:0]     mem [DEPTH];
    logic [DATA_WIDTH-1:0]     mem_rd_reg;
    logic                      wr_en, rd_en;
    logic [IW-1:0]             wr_idx, rd_idx, push_idx;
    logic [DATA_WIDTH-1:0]     wr_data;
    logic [DATA_WIDTH+rdq_pkg::IO_W-1:0] din_ext, dout_ext;
    logic [CAPW+rdq_pkg::COUNT_W-1:0]    count_ext;

    logic                      s_fire, a_advance;
    logic                      a_valid_reg;
    rdq_pkg::rdq_result_t      a_info_reg, a_info_next;
    logic                      m_valid_reg;
    rdq_pkg::rdq_result_t      m_info_reg;
    logic [rdq_pkg::IO_W-1:0]  m_data_reg;

    assign cap       = eff_cap(capacity_reg);
    assign a_advance = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || a_advance;
    assign s_fire    = s_valid && s_ready;

    assign din_ext = {{DATA_WIDTH{1'b0}}, s_data_in};
    assign wr_data = din_ext[DATA_WIDTH-1:0];

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        wr_idx    = head_reg;
        rd_idx    = head_reg;
        push_idx  = (s_command == rdq_pkg::CMD_PUSH_HEAD) ? head_reg : tail_reg;
        a_info_next.status   = rdq_pkg::ST_OK;
        a_info_next.has_data = 1'b0;
        case (s_command)
            rdq_pkg::CMD_PUSH_HEAD, rdq_pkg::CMD_PUSH_TAIL: begin
                if (occ_reg >= cap) begin
                    a_info_next.status = rdq_pkg::ST_FULL;
                end else begin
                    wr_en    = s_fire;
                    occ_next = occ_reg + 1'b1;
                    if (occ_reg == '0) begin
                        if (CAPW'(push_idx) >= cap) begin
                            push_idx = '0;
                        end
                        head_next = push_idx;
                        tail_next = push_idx;
                        wr_idx    = push_idx;
                    end else if (s_command == rdq_pkg::CMD_PUSH_HEAD) begin
                        head_next = ring_dec(head_reg, cap);
                        wr_idx    = head_next;
                    end else begin
                        tail_next = ring_inc(tail_reg, cap);
                        wr_idx    = tail_next;
                    end
                end
            end
            rdq_pkg::CMD_POP_HEAD, rdq_pkg::CMD_POP_TAIL,
            rdq_pkg::CMD_PEEK_HEAD, rdq_pkg::CMD_PEEK_TAIL: begin
                if (occ_reg == '0) begin
                    a_info_next.status = rdq_pkg::ST_EMPTY;
                end else begin
                    rd_en = s_fire;
                    a_info_next.has_data = 1'b1;
                    if (s_command == rdq_pkg::CMD_POP_HEAD ||
                        s_command == rdq_pkg::CMD_PEEK_HEAD) begin
                        rd_idx = head_reg;
                    end else begin
                        rd_idx = tail_reg;
                    end
                    if (s_command == rdq_pkg::CMD_POP_HEAD) begin
                        head_next = ring_inc(head_reg, cap);
                        occ_next  = occ_reg - 1'b1;
                    end else if (s_command == rdq_pkg::CMD_POP_TAIL) begin
                        tail_next = ring_dec(tail_reg, cap);
                        occ_next  = occ_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        count_ext = {{rdq_pkg::COUNT_W{1'b0}}, occ_next};
        a_info_next.count = count_ext[rdq_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= rdq_pkg::RESET_CAPACITY;
            head_reg     <= half_cap(eff_cap(rdq_pkg::RESET_CAPACITY));
            tail_reg     <= half_cap(eff_cap(rdq_pkg::RESET_CAPACITY));
            occ_reg      <= '0;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
            head_reg     <= half_cap(eff_cap(cfg_wr_data));
            tail_reg     <= half_cap(eff_cap(cfg_wr_data));
            occ_reg      <= '0;
        end else if (s_fire) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_rd_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_fire) begin
            a_valid_reg <= 1'b1;
        end else if (a_advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_info_reg <= a_info_next;
        end
    end

    assign dout_ext = {{rdq_pkg::IO_W{1'b0}}, mem_rd_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            m_info_reg <= a_info_reg;
            m_data_reg <= a_info_reg.has_data ? dout_ext[rdq_pkg::IO_W-1:0] : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;
    assign m_status   = m_info_reg.status;
    assign m_count    = m_info_reg.count;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= cap)
        else $error("occupancy above capacity");

    a_single_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == CAPW'(1) |-> head_reg == tail_reg)
        else $error("head and tail differ with one element");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rdq_pkg::ST_EMPTY |-> m_count == '0 && m_data_out == '0)
        else $error("empty result with nonzero count or data");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for ring_deque: directed table then random command words.
// Depends on rdq_pkg and ring_deque; a local deque predictor gives results for untyped words.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;
    localparam int SLOT_COUNT      = 16;
    localparam int SLOT_IW         = $clog2(SLOT_COUNT);
    localparam int CYCLE_LIMIT     = 400000;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_ROWS        = 30;

    typedef struct packed {
        logic [rdq_pkg::IO_W-1:0]    data;
        logic [1:0]                  status;
        logic [rdq_pkg::COUNT_W-1:0] count;
    } deque_reply_t;

    typedef struct packed {
        logic                        is_cfg;
        logic [rdq_pkg::CAP_W-1:0]   cap;
        logic [2:0]                  cmd;
        logic [rdq_pkg::IO_W-1:0]    din;
        logic                        typed;
        logic [rdq_pkg::IO_W-1:0]    exp_data;
        logic [1:0]                  exp_status;
        logic [rdq_pkg::COUNT_W-1:0] exp_count;
    } step_row_t;

    // cfg rows: capacity write; typed rows carry a hand-written result
    localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_HEAD, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_EMPTY, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_TAIL, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_EMPTY, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PEEK_HEAD, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_EMPTY, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PEEK_TAIL, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_EMPTY, 5'd0},
        '{1'b0, 5'd0, CMD_RSVD_6, 32'hFFFFFFFF, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, CMD_RSVD_7, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_HEAD, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_PEEK_HEAD, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_TAIL, 32'hFFFFFFFF, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd2},
        '{1'b0, 5'd0, rdq_pkg::CMD_PEEK_TAIL, 32'h0, 1'b1, 32'hFFFFFFFF, rdq_pkg::ST_OK, 5'd2},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_HEAD, 32'hA5A5A5A5, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd3},
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_HEAD, 32'h0, 1'b1, 32'hA5A5A5A5, rdq_pkg::ST_OK, 5'd2},
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_TAIL, 32'h0, 1'b1, 32'hFFFFFFFF, rdq_pkg::ST_OK, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_HEAD, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_TAIL, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_EMPTY, 5'd0},
        '{1'b1, 5'd1, rdq_pkg::CMD_PUSH_HEAD, 32'h0, 1'b0, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_TAIL, 32'h12345678, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_HEAD, 32'h00000001, 1'b1, 32'h0, rdq_pkg::ST_FULL, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_PEEK_TAIL, 32'h0, 1'b1, 32'h12345678, rdq_pkg::ST_OK, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_TAIL, 32'h0, 1'b1, 32'h12345678, rdq_pkg::ST_OK, 5'd0},
        '{1'b1, 5'd0, rdq_pkg::CMD_PUSH_HEAD, 32'h0, 1'b0, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_HEAD, 32'h80000000, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_TAIL, 32'h00000007, 1'b1, 32'h0, rdq_pkg::ST_FULL, 5'd1},
        '{1'b1, 5'd31, rdq_pkg::CMD_PUSH_HEAD, 32'h0, 1'b0, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PEEK_HEAD, 32'h0, 1'b1, 32'h0, rdq_pkg::ST_EMPTY, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_TAIL, 32'h5A5A5A5A, 1'b0, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_POP_TAIL, 32'h0, 1'b0, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b1, 5'd2, rdq_pkg::CMD_PUSH_HEAD, 32'h0, 1'b0, 32'h0, rdq_pkg::ST_OK, 5'd0},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_HEAD, 32'h0000FFFF, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd1},
        '{1'b0, 5'd0, rdq_pkg::CMD_PUSH_TAIL, 32'h3C3C3C3C, 1'b1, 32'h0, rdq_pkg::ST_OK, 5'd2}
    };

    localparam logic [rdq_pkg::CAP_W-1:0] CAP_PICKS [6] = '{5'd2, 5'd16, 5'd1, 5'd31, 5'd0, 5'd3};

    logic                         aclk;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic [2:0]                   s_command   = rdq_pkg::CMD_PUSH_HEAD;
    logic [rdq_pkg::IO_W-1:0]     s_data_in   = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic [rdq_pkg::IO_W-1:0]     m_data_out;
    logic [1:0]                   m_status;
    logic [rdq_pkg::COUNT_W-1:0]  m_count;
    logic                         cfg_wr_en   = 1'b0;
    logic [rdq_pkg::CAP_W-1:0]    cfg_wr_data = '0;

    // predictor state
    logic [rdq_pkg::CAP_W-1:0]    cap_reg;
    int                           head_ptr;
    int                           tail_ptr;
    int                           occ;
    logic [rdq_pkg::IO_W-1:0]     slot_mem [SLOT_COUNT];

    deque_reply_t        reply_q [$];
    bit                  gaps_on = 1'b1;
    int                  errors  = 0;
    int unsigned         cycles  = 0;

    ring_deque #(
        .DEPTH      (16),
        .DATA_WIDTH (32)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_status    (m_status),
        .m_count     (m_count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int live_capacity();
        if (cap_reg == 0) return 1;
        if (cap_reg > SLOT_COUNT) return SLOT_COUNT;
        return int'(cap_reg);
    endfunction

    function automatic int ring_next(int i, int cap);
        return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function automatic int ring_prev(int i, int cap);
        return (i == 0 || i >= cap) ? cap - 1 : i - 1;
    endfunction

    function automatic void clear_deque();
        head_ptr = live_capacity() / 2;
        tail_ptr = head_ptr;
        occ      = 0;
    endfunction

    function automatic deque_reply_t apply_command(logic [2:0] cmd,
                                                   logic [rdq_pkg::IO_W-1:0] din);
        deque_reply_t r;
        int cap;
        int idx;
        r        = '0;
        r.status = rdq_pkg::ST_OK;
        cap      = live_capacity();
        case (cmd)
            rdq_pkg::CMD_PUSH_HEAD, rdq_pkg::CMD_PUSH_TAIL: begin
                if (occ >= cap) begin
                    r.status = rdq_pkg::ST_FULL;
                end else begin
                    if (occ == 0) begin
                        idx = (cmd == rdq_pkg::CMD_PUSH_HEAD) ? head_ptr : tail_ptr;
                        if (idx >= cap) idx = 0;
                        head_ptr = idx;
                        tail_ptr = idx;
                    end else if (cmd == rdq_pkg::CMD_PUSH_HEAD) begin
                        head_ptr = ring_prev(head_ptr, cap);
                        idx      = head_ptr;
                    end else begin
                        tail_ptr = ring_next(tail_ptr, cap);
                        idx      = tail_ptr;
                    end
                    slot_mem[SLOT_IW'(idx % SLOT_COUNT)] = din;
                    occ++;
                end
            end
            rdq_pkg::CMD_POP_HEAD, rdq_pkg::CMD_POP_TAIL,
            rdq_pkg::CMD_PEEK_HEAD, rdq_pkg::CMD_PEEK_TAIL: begin
                if (occ == 0) begin
                    r.status = rdq_pkg::ST_EMPTY;
                end else begin
                    idx = (cmd == rdq_pkg::CMD_POP_HEAD || cmd == rdq_pkg::CMD_PEEK_HEAD)
                        ? head_ptr : tail_ptr;
                    r.data = slot_mem[SLOT_IW'(idx % SLOT_COUNT)];
                    if (cmd == rdq_pkg::CMD_POP_HEAD) begin
                        head_ptr = ring_next(head_ptr, cap);
                        occ--;
                    end else if (cmd == rdq_pkg::CMD_POP_TAIL) begin
                        tail_ptr = ring_prev(tail_ptr, cap);
                        occ--;
                    end
                end
            end
            default: ;
        endcase
        r.count = rdq_pkg::COUNT_W'(occ);
        return r;
    endfunction

    task automatic send_word(logic [2:0] cmd, logic [rdq_pkg::IO_W-1:0] din,
                             logic typed, deque_reply_t given);
        deque_reply_t predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_data_in <= din;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_command(cmd, din);
        reply_q.push_back(typed ? given : predicted);
    endtask

    task automatic write_capacity(logic [rdq_pkg::CAP_W-1:0] value);
        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = value;
        clear_deque();
    endtask

    // result side back-pressure
    initial begin
        int n;
        wait (aresetn);
        forever begin
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                m_ready <= 1'b0;
            end else begin
                n = $urandom_range(1, 16);
                m_ready <= 1'b1;
            end
            repeat (n) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        deque_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected result word: data_out %h status %0d count %0d",
                       m_data_out, m_status, m_count);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (m_data_out !== want.data) begin
                    $error("data_out: expected %h, actual %h", want.data, m_data_out);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    errors++;
                end
                if (m_count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, m_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [2:0]               cmd;
        logic [rdq_pkg::IO_W-1:0] din;
        int                       push_pct;
        cap_reg = rdq_pkg::RESET_CAPACITY;
        clear_deque();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED_ROWS[i].is_cfg) begin
                write_capacity(DIRECTED_ROWS[i].cap);
            end else begin
                send_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].din, DIRECTED_ROWS[i].typed,
                          '{DIRECTED_ROWS[i].exp_data, DIRECTED_ROWS[i].exp_status,
                            DIRECTED_ROWS[i].exp_count});
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if (p >= N_PHASES - 2) gaps_on = 1'b0;
            write_capacity(p < 6 ? CAP_PICKS[p] : rdq_pkg::CAP_W'($urandom_range(0, 31)));
            push_pct = $urandom_range(25, 75);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 99) < 3) begin
                    cmd = $urandom_range(0, 1) ? CMD_RSVD_7 : CMD_RSVD_6;
                end else if ($urandom_range(0, 99) < push_pct) begin
                    cmd = $urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_TAIL
                                               : rdq_pkg::CMD_PUSH_HEAD;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       cmd = rdq_pkg::CMD_POP_HEAD;
                        1:       cmd = rdq_pkg::CMD_POP_TAIL;
                        2:       cmd = rdq_pkg::CMD_PEEK_HEAD;
                        default: cmd = rdq_pkg::CMD_PEEK_TAIL;
                    endcase
                end
                case ($urandom_range(0, 7))
                    0:       din = '0;
                    1:       din = '1;
                    default: din = $urandom();
                endcase
                send_word(cmd, din, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
